/* hdl/ute_pkg.sv */
`default_nettype none

package ute_pkg;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [15:0] FIRST_YEAR   = 16'd1970;
  localparam logic [15:0] LAST_YEAR    = 16'd2037;
  localparam logic [19:0] MICROS_MAX   = 20'd999999;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [5:0]  MINUTE_MAX   = 6'd59;
  localparam logic [5:0]  SECOND_MAX   = 6'd59;
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;
  localparam logic [14:0] DAYS_PER_YEAR = 15'd365;

  // 25 * INV25 == 1 mod 2**16: x is a multiple of 25 exactly when
  // x * INV25 mod 2**16 <= floor((2**16 - 1) / 25)
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'd2621;

  localparam int DAYS_W = 15;  // days since 1970 up to 2037-12-31
  localparam int TOD_W  = 17;  // seconds of day
  localparam int EPOCH_W = 31;

  typedef logic [DAYS_W-1:0] days_t;
  typedef logic [TOD_W-1:0]  tod_t;

  // date stage result handed to the multiply stage
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    days_t      days;
    tod_t       tod;
  } date_word_t;

  // length of month in a common year, 0 for a month code that means nothing
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    len = 5'd0;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    d = 9'd0;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/ute_date_stage.sv */
`default_nettype none

module ute_date_stage
  import ute_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [15:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [5:0]  sec_field,
  input  wire logic [19:0] micros,
  output date_word_t       date_word
);

  // stage a: field limits, divisibility by 25, time of day
  logic       a_valid;
  logic [3:0] a_year_lo;
  logic       a_div25;
  logic       a_basic_ok;
  logic       a_in_range;
  logic [6:0] a_yoff;
  logic [3:0] a_month;
  logic [4:0] a_day;
  tod_t       a_tod;

  logic [31:0] inv_prod;
  logic        basic_ok;
  logic        in_range;
  logic [15:0] yoff_full;
  tod_t        tod;

  assign inv_prod  = {16'd0, year} * {16'd0, INV25};
  assign basic_ok  = (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0)
                     && (hour <= HOUR_MAX) && (minute <= MINUTE_MAX)
                     && (sec_field <= SECOND_MAX) && (micros <= MICROS_MAX);
  assign in_range  = (year >= FIRST_YEAR) && (year <= LAST_YEAR);
  assign yoff_full = year - FIRST_YEAR;
  // cannot wrap: even the largest field values fit in TOD_W bits
  assign tod = TOD_W'({12'd0, hour} * SEC_PER_HOUR)
             + TOD_W'({11'd0, minute} * SEC_PER_MIN)
             + TOD_W'(sec_field);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_year_lo  <= year[3:0];
    a_div25    <= (inv_prod[15:0] <= DIV25_LIMIT);
    a_basic_ok <= basic_ok;
    a_in_range <= in_range;
    a_yoff     <= yoff_full[6:0];
    a_month    <= month;
    a_day      <= day;
    a_tod      <= tod;
  end

  // stage b: leap year, day-of-month check, day count
  logic       leap;
  logic       feb_extra;
  logic       late_extra;
  logic [4:0] mlen;
  logic       fields_ok;
  logic [7:0] leaps_before;
  days_t      days;
  logic [1:0] status;

  assign leap       = (a_year_lo[1:0] == 2'd0) && (!a_div25 || a_year_lo == 4'd0);
  assign feb_extra  = (a_month == 4'd2) && leap;
  assign late_extra = (a_month > 4'd2) && leap;
  assign mlen       = month_len(a_month) + {4'd0, feb_extra};
  assign fields_ok  = a_basic_ok && (a_day <= mlen);
  // leap years from 1970 up to the year before; 2000 is the only century
  assign leaps_before = ({1'b0, a_yoff} + 8'd1) >> 2;
  assign days = DAYS_W'({8'd0, a_yoff} * DAYS_PER_YEAR)
              + DAYS_W'(leaps_before)
              + DAYS_W'(days_before_month(a_month))
              + DAYS_W'(late_extra)
              + DAYS_W'(a_day) - DAYS_W'(1);

  always_comb begin
    priority if (!fields_ok) begin
      status = ST_INVALID;
    end else if (!a_in_range) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      date_word.valid <= 1'b0;
    end else begin
      date_word.valid <= a_valid;
    end
    date_word.status <= status;
    date_word.days   <= days;
    date_word.tod    <= a_tod;
  end

endmodule

`default_nettype wire

/* hdl/utc_fields_to_epoch_seconds.sv */
`default_nettype none

// channel   | handshake          | ports
// ----------+--------------------+---------------------------------------------
// command   | start & !busy      | year, month, day, hour, minute, sec_field,
//           |                    | micros
// result    | done (one cycle)   | status, epoch_seconds
//
// one word enters per cycle while not in reset; its result shows on done after
// passing the four register stages: field checks and the mod-25 multiply,
// leap and day count, the days * 86400 multiply, and the final add.
// rst is synchronous and clears the stage valid bits; busy is high during
// reset only. the receiver cannot stall, so the pipeline never holds.

module utc_fields_to_epoch_seconds
  import ute_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [15:0]         year,
  input  wire logic [3:0]          month,
  input  wire logic [4:0]          day,
  input  wire logic [4:0]          hour,
  input  wire logic [5:0]          minute,
  input  wire logic [5:0]          sec_field,
  input  wire logic [19:0]         micros,
  output logic                     done,
  output logic [1:0]               status,
  output logic [EPOCH_W-1:0]       epoch_seconds
);

  // nothing backs up, so a word is refused only while in reset
  assign busy = rst;

  date_word_t date_word;

  // stages a and b: field validation, leap year and days since 1970
  ute_date_stage u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .year      (year),
    .month     (month),
    .day       (day),
    .hour      (hour),
    .minute    (minute),
    .sec_field (sec_field),
    .micros    (micros),
    .date_word (date_word)
  );

  // stage c: days to seconds
  logic               c_valid;
  logic [1:0]         c_status;
  logic [EPOCH_W-1:0] c_day_secs;
  tod_t               c_tod;
  logic [31:0]        day_prod;

  // largest in-range day count times 86400 still fits in 31 bits
  assign day_prod = {17'd0, date_word.days} * {15'd0, SEC_PER_DAY};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= date_word.valid;
    end
    c_status   <= date_word.status;
    c_day_secs <= day_prod[EPOCH_W-1:0];
    c_tod      <= date_word.tod;
  end

  // stage d: add time of day; an error word carries zero seconds.
  // for years up to 2037 the sum stays below 2**31, so no overflow path
  logic [EPOCH_W-1:0] epoch_next;

  assign epoch_next = (c_status == ST_OK)
                    ? c_day_secs + EPOCH_W'(c_tod)
                    : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_valid;
    end
    status        <= c_status;
    epoch_seconds <= epoch_next;
  end

  // every accepted word comes out as a result on done
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word did not produce a result");

  // no result without a word accepted earlier at the pipeline input
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching command");

  // an error status always carries zero seconds
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (epoch_seconds == '0))
    else $error("nonzero epoch on error status");

endmodule

`default_nettype wire
